@@ hw/rtl/radix_number_string_lexer_macros.svh @@
// Assertion macros for the radix number string lexer.
`ifndef RADIX_NUMBER_STRING_LEXER_MACROS_SVH
`define RADIX_NUMBER_STRING_LEXER_MACROS_SVH

`ifndef SYNTHESIS
`define RNSL_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rnsl assertion failed");
`define RNSL_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("rnsl assertion failed");
`else
`define RNSL_ASSERT(lbl, prop)
`define RNSL_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ hw/rtl/rnsl_pkg.sv @@
package rnsl_pkg;

    localparam int CNT_W      = 16;
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LVL_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_US    = 8'h5F;

    localparam logic [5:0] RADIX_MIN   = 6'd2;
    localparam logic [5:0] RADIX_MAX   = 6'd36;
    localparam logic [5:0] RADIX_RESET = 6'd10;
    localparam logic [6:0] NOT_A_DIGIT = 7'h7F;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_SIGN,
        PH_ZERO,
        PH_DIGIT,
        PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_LEAD_US,
        ST_NO_DIGITS,
        ST_TRAIL_US
    } status_t;

    typedef enum logic {
        KIND_DIGIT,
        KIND_FINAL
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [5:0]       digit;
        logic             negative;
        status_t          status;
        logic [15:0]      processed_count;
        logic [15:0]      digit_count;
        logic             last_of_run;
    } result_t;

    // One queue entry: everything a single character produces.
    typedef struct packed {
        logic    two;
        result_t res0;
        result_t res1;
    } record_t;

    function automatic logic [6:0] char_digit(input logic [7:0] c);
        logic [6:0] v;
        v = NOT_A_DIGIT;
        if (c >= 8'h30 && c <= 8'h39)
            v = 7'(c - 8'h30);
        else if (c >= 8'h61 && c <= 8'h7A)
            v = 7'(c - 8'h61 + 8'd10);
        else if (c >= 8'h41 && c <= 8'h5A)
            v = 7'(c - 8'h41 + 8'd10);
        return v;
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
    endfunction

    function automatic logic [15:0] report(input logic [CNT_W-1:0] v);
        logic [31:0] w;
        w = 32'(v);
        return w[15:0];
    endfunction

endpackage

@@ hw/rtl/rnsl_front.sv @@
module rnsl_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    input  logic [5:0]            radix,
    input  logic                  accept,
    input  logic [7:0]            ch,
    input  logic                  first,
    output logic                  push,
    output rnsl_pkg::record_t     rec
);

    rnsl_pkg::phase_t           phase_reg, phase_next;
    logic                       sign_reg, sign_next;
    logic [rnsl_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [rnsl_pkg::CNT_W-1:0] dcnt_reg, dcnt_next;
    logic                       pu_reg, pu_next;
    logic                       zs_reg, zs_next;
    logic [5:0]                 radix_reg;
    logic [5:0]                 base;
    logic [6:0]                 cv;
    logic                       fin, emit_dig, zero_dig, handled;
    rnsl_pkg::status_t          fin_st;
    logic [rnsl_pkg::CNT_W-1:0] fin_proc;
    rnsl_pkg::result_t          dig_res, fin_res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg <= rnsl_pkg::RADIX_RESET;
        end
        else if (cfg_valid)
        begin
            radix_reg <= radix;
        end
    end

    assign base = (radix_reg < rnsl_pkg::RADIX_MIN) ? rnsl_pkg::RADIX_MIN :
                  (radix_reg > rnsl_pkg::RADIX_MAX) ? rnsl_pkg::RADIX_MAX : radix_reg;
    assign cv   = rnsl_pkg::char_digit(ch);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= rnsl_pkg::PH_IDLE;
            sign_reg  <= 1'b0;
            pos_reg   <= '0;
            dcnt_reg  <= '0;
            pu_reg    <= 1'b0;
            zs_reg    <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg <= phase_next;
            sign_reg  <= sign_next;
            pos_reg   <= pos_next;
            dcnt_reg  <= dcnt_next;
            pu_reg    <= pu_next;
            zs_reg    <= zs_next;
        end
    end

    always_comb
    begin
        phase_next = first ? rnsl_pkg::PH_SIGN : phase_reg;
        sign_next  = first ? 1'b0 : sign_reg;
        pos_next   = first ? '0 : pos_reg;
        dcnt_next  = first ? '0 : dcnt_reg;
        pu_next    = first ? 1'b0 : pu_reg;
        zs_next    = first ? 1'b0 : zs_reg;
        fin        = 1'b0;
        fin_st     = rnsl_pkg::ST_OK;
        emit_dig   = 1'b0;
        zero_dig   = 1'b0;
        handled    = 1'b0;

        if (phase_next == rnsl_pkg::PH_SIGN)
        begin
            if (ch == rnsl_pkg::CH_MINUS || ch == rnsl_pkg::CH_PLUS)
            begin
                if (ch == rnsl_pkg::CH_MINUS)
                    sign_next = ~sign_next;
                pos_next = rnsl_pkg::sat_inc(pos_next);
                handled  = 1'b1;
            end
            else if (ch == rnsl_pkg::CH_US)
            begin
                fin     = 1'b1;
                fin_st  = rnsl_pkg::ST_LEAD_US;
                handled = 1'b1;
            end
            else
            begin
                phase_next = rnsl_pkg::PH_ZERO;
            end
        end

        if (!handled && phase_next == rnsl_pkg::PH_ZERO)
        begin
            if (ch == rnsl_pkg::CH_ZERO)
            begin
                pos_next = rnsl_pkg::sat_inc(pos_next);
                zs_next  = 1'b1;
                pu_next  = 1'b0;
                handled  = 1'b1;
            end
            else if (ch == rnsl_pkg::CH_NUL)
            begin
                if (zs_next)
                begin
                    dcnt_next = rnsl_pkg::sat_inc(dcnt_next);
                    zero_dig  = 1'b1;
                end
                fin     = 1'b1;
                handled = 1'b1;
            end
            else
            begin
                phase_next = rnsl_pkg::PH_DIGIT;
            end
        end

        if (!handled && phase_next == rnsl_pkg::PH_DIGIT)
        begin
            if (ch == rnsl_pkg::CH_US)
            begin
                pos_next = rnsl_pkg::sat_inc(pos_next);
                pu_next  = 1'b1;
            end
            else if (ch != rnsl_pkg::CH_NUL && cv < {1'b0, base})
            begin
                pos_next  = rnsl_pkg::sat_inc(pos_next);
                dcnt_next = rnsl_pkg::sat_inc(dcnt_next);
                pu_next   = 1'b0;
                emit_dig  = 1'b1;
            end
            else
            begin
                fin = 1'b1;
            end
        end

        fin_proc = pos_next;
        if (fin && fin_st == rnsl_pkg::ST_OK)
        begin
            if (dcnt_next == '0)
            begin
                fin_st = rnsl_pkg::ST_NO_DIGITS;
            end
            else if (pu_next)
            begin
                fin_st = rnsl_pkg::ST_TRAIL_US;
                if (pos_next != '0)
                    fin_proc = pos_next - 1'b1;
            end
        end
        if (fin)
            phase_next = rnsl_pkg::PH_DONE;
    end

    always_comb
    begin
        dig_res.kind            = rnsl_pkg::KIND_DIGIT;
        dig_res.digit           = emit_dig ? cv[5:0] : 6'd0;
        dig_res.negative        = sign_next;
        dig_res.status          = rnsl_pkg::ST_OK;
        dig_res.processed_count = rnsl_pkg::report(pos_next);
        dig_res.digit_count     = rnsl_pkg::report(dcnt_next);
        dig_res.last_of_run     = emit_dig;

        fin_res.kind            = rnsl_pkg::KIND_FINAL;
        fin_res.digit           = 6'd0;
        fin_res.negative        = sign_next;
        fin_res.status          = fin_st;
        fin_res.processed_count = rnsl_pkg::report(fin_proc);
        fin_res.digit_count     = rnsl_pkg::report(dcnt_next);
        fin_res.last_of_run     = 1'b1;

        rec.two  = zero_dig;
        rec.res0 = (zero_dig || emit_dig) ? dig_res : fin_res;
        rec.res1 = fin_res;
    end

    assign push = accept && (fin || emit_dig);

endmodule

@@ hw/rtl/rnsl_fifo.sv @@
`include "radix_number_string_lexer_macros.svh"

module rnsl_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  rnsl_pkg::record_t wdata,
    input  logic              pop,
    output rnsl_pkg::record_t head,
    output logic              empty,
    output logic              full
);

    rnsl_pkg::record_t          mem_reg [rnsl_pkg::FIFO_DEPTH];
    logic [rnsl_pkg::PTR_W-1:0] wr_reg, wr_next;
    logic [rnsl_pkg::PTR_W-1:0] rd_reg, rd_next;
    logic [rnsl_pkg::LVL_W-1:0] lvl_reg, lvl_next;

    assign empty = (lvl_reg == '0);
    assign full  = (lvl_reg == rnsl_pkg::LVL_W'(rnsl_pkg::FIFO_DEPTH));
    assign head  = mem_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_reg] <= wdata;
    end

    always_comb
    begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        lvl_next = lvl_reg;
        if (push && !pop)
            lvl_next = lvl_reg + 1'b1;
        else if (pop && !push)
            lvl_next = lvl_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            lvl_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            lvl_reg <= lvl_next;
        end
    end

    `RNSL_ASSERT(a_no_push_full, !(push && full))
    `RNSL_ASSERT(a_no_pop_empty, !(pop && empty))
    `RNSL_ASSERT(a_level_range, lvl_reg <= rnsl_pkg::LVL_W'(rnsl_pkg::FIFO_DEPTH))

endmodule

@@ hw/rtl/rnsl_back.sv @@
`include "radix_number_string_lexer_macros.svh"

module rnsl_back (
    input  logic              clk,
    input  logic              rst_n,
    input  rnsl_pkg::record_t head,
    input  logic              empty,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output rnsl_pkg::result_t res
);

    logic second_reg, second_next;
    logic fire;

    assign result_valid = !empty;
    assign res          = second_reg ? head.res1 : head.res0;
    assign fire         = result_valid && !result_stall;
    assign pop          = fire && (!head.two || second_reg);

    always_comb
    begin
        second_next = second_reg;
        if (fire)
            second_next = head.two && !second_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            second_reg <= 1'b0;
        else
            second_reg <= second_next;
    end

    `RNSL_ASSERT(a_second_has_pair, !second_reg || (!empty && head.two))
    `RNSL_ASSERT_NEXT(a_second_after_first, fire && head.two && !second_reg, second_reg)

endmodule

@@ hw/rtl/radix_number_string_lexer.sv @@
// Radix number string lexer: one character beat is accepted per clock while
// item_stall is low; the classifier updates the lexing state and writes each
// character's results (none, one, or a digit plus final summary) into a
// four-entry queue, and the result side sends one result beat per clock from
// the queue head while result_stall is low. A NUL after only zeros yields two
// result beats from one queue entry; item_stall rises only when the queue is
// full. The radix register is written through cfg_valid/cfg_ready, which is
// always ready, and must only change while no string is in flight.
module radix_number_string_lexer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  radix,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [7:0]  ch,
    input  logic        first,
    output logic        result_valid,
    input  logic        result_stall,
    output logic        kind,
    output logic [5:0]  digit,
    output logic        negative,
    output logic [1:0]  status,
    output logic [15:0] processed_count,
    output logic [15:0] digit_count,
    output logic        last_of_run
);

    logic              accept, push, pop, empty, full;
    rnsl_pkg::record_t rec, head;
    rnsl_pkg::result_t res;

    assign cfg_ready  = 1'b1;
    assign item_stall = full;
    assign accept     = item_valid && !full;

    rnsl_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .radix     (radix),
        .accept    (accept),
        .ch        (ch),
        .first     (first),
        .push      (push),
        .rec       (rec)
    );

    rnsl_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (rec),
        .pop   (pop),
        .head  (head),
        .empty (empty),
        .full  (full)
    );

    rnsl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .res          (res)
    );

    assign kind            = res.kind;
    assign digit           = res.digit;
    assign negative        = res.negative;
    assign status          = res.status;
    assign processed_count = res.processed_count;
    assign digit_count     = res.digit_count;
    assign last_of_run     = res.last_of_run;

endmodule
